// ----- hdl/heading_calibrate_filter_pd_steer_core_macros.svh -----
// Assertion macros for the heading controller core
`ifndef HEADING_CALIBRATE_FILTER_PD_STEER_CORE_MACROS_SVH
`define HEADING_CALIBRATE_FILTER_PD_STEER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define HCF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define HCF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/hcf_pkg.sv -----
// Shared types, constants and helpers for the heading controller
package hcf_pkg;

  localparam int HeadingLimit = 36000;
  localparam int Q12One       = 4096;
  localparam int AccW         = 38;

  // configuration register indexes
  localparam logic [2:0] REG_PROP_GAIN      = 3'd0;
  localparam logic [2:0] REG_DERIV_GAIN     = 3'd1;
  localparam logic [2:0] REG_FILTER_WEIGHT  = 3'd2;
  localparam logic [2:0] REG_WARMUP_SAMPLES = 3'd3;
  localparam logic [2:0] REG_STRAIGHT_DRIVE = 3'd4;

  // steering command codes
  localparam logic [1:0] CMD_NONE     = 2'd0;
  localparam logic [1:0] CMD_STRAIGHT = 2'd1;
  localparam logic [1:0] CMD_LEFT     = 2'd2;
  localparam logic [1:0] CMD_RIGHT    = 2'd3;

  typedef struct packed {
    logic en;   // update accumulator this cycle
    logic clr;  // load product instead of adding
  } mac_ctl_t;

  function automatic logic signed [16:0] clamp_heading(input logic signed [AccW-1:0] v);
    logic signed [16:0] r;
    if (v > AccW'(HeadingLimit)) begin
      r = 17'(HeadingLimit);
    end else if (v < -AccW'(HeadingLimit)) begin
      r = -17'(HeadingLimit);
    end else begin
      r = v[16:0];
    end
    return r;
  endfunction

endpackage

// ----- hdl/hcf_mac.sv -----
// Shared signed multiply-accumulate unit used by filter and PD steps
module hcf_mac
  import hcf_pkg::*;
(
  input  logic                   clk,
  input  mac_ctl_t               ctl,
  input  logic signed [16:0]     op_a,
  input  logic signed [18:0]     op_b,
  output logic signed [AccW-1:0] acc
);

  logic signed [35:0]     prod;
  logic signed [AccW-1:0] acc_r;
  logic signed [AccW-1:0] acc_nxt;

  assign prod = op_a * op_b;

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.en) begin
      if (ctl.clr) begin
        acc_nxt = AccW'(prod);
      end else begin
        acc_nxt = acc_r + AccW'(prod);
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

// ----- hdl/heading_calibrate_filter_pd_steer_core.sv -----
// Each word goes S_IDLE, S_PRE, S_F1-S_F3 (filter), S_ERR, S_P1-S_P2 (PD), S_OUT; S_OUT
// waits on output stall. The calibrating sample and an invalid one once calibrated skip
// the filter; before calibration S_PRE goes to S_OUT. A new word is taken only in S_IDLE;
// the single shared MAC unit runs four products in turn (two for the filter, two for PD).
// Reset (rst_n low, synchronous): registers to defaults, warm-up count, calibration,
// offset, filter and previous error cleared; output empty.
module heading_calibrate_filter_pd_steer_core
  import hcf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_sample_valid,
  input  logic signed [15:0]  in_yaw_raw,
  input  logic signed [15:0]  in_target_heading,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_steer_command,
  output logic [15:0]         out_drive_level,
  output logic signed [16:0]  out_heading_now,
  output logic                out_calibrated
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PRE  = 4'd1;
  localparam logic [3:0] S_F1   = 4'd2;
  localparam logic [3:0] S_F2   = 4'd3;
  localparam logic [3:0] S_F3   = 4'd4;
  localparam logic [3:0] S_ERR  = 4'd5;
  localparam logic [3:0] S_P1   = 4'd6;
  localparam logic [3:0] S_P2   = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0] state_r, state_nxt;

  // configuration
  logic [15:0] pgain_r, dgain_r, sdrive_r;
  logic [12:0] fweight_r;
  logic [11:0] warmup_r;

  // item
  logic               smp_valid_r;
  logic signed [15:0] raw_r, tgt_r;

  // persistent state
  logic [11:0]        cnt_r, cnt_nxt;
  logic               cal_r, cal_nxt;
  logic signed [15:0] ofs_r, ofs_nxt;
  logic signed [16:0] filt_r, filt_nxt;
  logic signed [17:0] prev_r, prev_nxt;

  // working registers
  logic signed [16:0] corr_r, corr_nxt;
  logic signed [16:0] hdg_r, hdg_nxt;
  logic signed [17:0] err_r, err_nxt;
  logic signed [18:0] diff_r, diff_nxt;

  // output word
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         cmd_r, cmd_nxt;
  logic [15:0]        drive_r, drive_nxt;
  logic signed [16:0] ohdg_r, ohdg_nxt;
  logic               ocal_r, ocal_nxt;

  mac_ctl_t               mac_ctl;
  logic signed [16:0]     mul_a;
  logic signed [18:0]     mul_b;
  logic signed [AccW-1:0] acc;

  logic [12:0]            w_sat, w_rest;
  logic [11:0]            cnt_inc;
  logic signed [16:0]     yaw_diff;
  logic signed [AccW-1:0] filt_q, u_adj, u_q, u_mag;
  logic                   can_load;

  hcf_mac u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .op_a (mul_a),
    .op_b (mul_b),
    .acc  (acc)
  );

  assign w_sat    = (fweight_r > 13'(Q12One)) ? 13'(Q12One) : fweight_r;
  assign w_rest   = 13'(Q12One) - w_sat;
  assign cnt_inc  = (cnt_r == 12'hFFF) ? cnt_r : cnt_r + 12'd1;
  assign yaw_diff = {raw_r[15], raw_r} - {ofs_r[15], ofs_r};
  // floor of (acc + half) / 4096
  assign filt_q   = (acc + AccW'(Q12One / 2)) >>> 12;
  // truncate toward zero
  assign u_adj    = acc[AccW-1] ? acc + AccW'(Q12One - 1) : acc;
  assign u_q      = u_adj >>> 12;
  assign u_mag    = u_q[AccW-1] ? -u_q : u_q;
  assign can_load = !out_valid_r || !out_stall;

  always_comb begin
    mac_ctl = '0;
    mul_a   = '0;
    mul_b   = '0;
    case (state_r)
      S_F1: begin
        mac_ctl = '{en: 1'b1, clr: 1'b1};
        mul_a   = {4'b0, w_rest};
        mul_b   = {{2{corr_r[16]}}, corr_r};
      end
      S_F2: begin
        mac_ctl = '{en: 1'b1, clr: 1'b0};
        mul_a   = {4'b0, w_sat};
        mul_b   = {{2{filt_r[16]}}, filt_r};
      end
      S_P1: begin
        mac_ctl = '{en: 1'b1, clr: 1'b1};
        mul_a   = {1'b0, pgain_r};
        mul_b   = {err_r[17], err_r};
      end
      S_P2: begin
        mac_ctl = '{en: 1'b1, clr: 1'b0};
        mul_a   = {1'b0, dgain_r};
        mul_b   = diff_r;
      end
      default: begin
        mac_ctl = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cal_nxt       = cal_r;
    ofs_nxt       = ofs_r;
    filt_nxt      = filt_r;
    prev_nxt      = prev_r;
    corr_nxt      = corr_r;
    hdg_nxt       = hdg_r;
    err_nxt       = err_r;
    diff_nxt      = diff_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd_nxt       = cmd_r;
    drive_nxt     = drive_r;
    ohdg_nxt      = ohdg_r;
    ocal_nxt      = ocal_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_PRE;
        end
      end
      S_PRE: begin
        if (!cal_r) begin
          if (smp_valid_r) begin
            cnt_nxt = cnt_inc;
            hdg_nxt = {raw_r[15], raw_r};
            if (raw_r != 16'sd0 && cnt_inc >= warmup_r) begin
              ofs_nxt   = raw_r;
              cal_nxt   = 1'b1;
              state_nxt = S_ERR;
            end else begin
              state_nxt = S_OUT;
            end
          end else begin
            hdg_nxt   = '0;
            state_nxt = S_OUT;
          end
        end else if (smp_valid_r) begin
          corr_nxt  = clamp_heading(AccW'(yaw_diff));
          state_nxt = S_F1;
        end else begin
          hdg_nxt   = '0;
          state_nxt = S_ERR;
        end
      end
      S_F1: state_nxt = S_F2;
      S_F2: state_nxt = S_F3;
      S_F3: begin
        hdg_nxt   = clamp_heading(filt_q);
        filt_nxt  = hdg_nxt;
        state_nxt = S_ERR;
      end
      S_ERR: begin
        err_nxt   = {{2{tgt_r[15]}}, tgt_r} - {hdg_r[16], hdg_r};
        diff_nxt  = {err_nxt[17], err_nxt} - {prev_r[17], prev_r};
        prev_nxt  = err_nxt;
        state_nxt = S_P1;
      end
      S_P1: state_nxt = S_P2;
      S_P2: state_nxt = S_OUT;
      S_OUT: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          ohdg_nxt      = hdg_r;
          ocal_nxt      = cal_r;
          if (!cal_r) begin
            cmd_nxt   = CMD_NONE;
            drive_nxt = '0;
          end else if (u_q == '0) begin
            cmd_nxt   = CMD_STRAIGHT;
            drive_nxt = sdrive_r;
          end else begin
            cmd_nxt   = u_q[AccW-1] ? CMD_RIGHT : CMD_LEFT;
            drive_nxt = (u_mag > AccW'(65535)) ? 16'hFFFF : u_mag[15:0];
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pgain_r     <= 16'd1843;
      dgain_r     <= 16'd2458;
      fweight_r   <= 13'd2867;
      warmup_r    <= 12'd2000;
      sdrive_r    <= '0;
      cnt_r       <= '0;
      cal_r       <= 1'b0;
      ofs_r       <= '0;
      filt_r      <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cal_r       <= cal_nxt;
      ofs_r       <= ofs_nxt;
      filt_r      <= filt_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_PROP_GAIN:      pgain_r   <= cfg_wdata;
          REG_DERIV_GAIN:     dgain_r   <= cfg_wdata;
          REG_FILTER_WEIGHT:  fweight_r <= cfg_wdata[12:0];
          REG_WARMUP_SAMPLES: warmup_r  <= cfg_wdata[11:0];
          REG_STRAIGHT_DRIVE: sdrive_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      smp_valid_r <= in_sample_valid;
      raw_r       <= in_yaw_raw;
      tgt_r       <= in_target_heading;
    end
    corr_r  <= corr_nxt;
    hdg_r   <= hdg_nxt;
    err_r   <= err_nxt;
    diff_r  <= diff_nxt;
    cmd_r   <= cmd_nxt;
    drive_r <= drive_nxt;
    ohdg_r  <= ohdg_nxt;
    ocal_r  <= ocal_nxt;
  end

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_steer_command = cmd_r;
  assign out_drive_level   = drive_r;
  assign out_heading_now   = ohdg_r;
  assign out_calibrated    = ocal_r;

`include "heading_calibrate_filter_pd_steer_core_macros.svh"

  `HCF_ASSERT_NEXT(a_cal_sticky, cal_r, cal_r, "calibration flag dropped")
  `HCF_ASSERT_NOW(a_uncal_word, out_valid && !out_calibrated,
                  out_steer_command == CMD_NONE && out_drive_level == 16'd0,
                  "uncalibrated word carries steering")
  `HCF_ASSERT_NOW(a_cal_word, out_valid && out_calibrated,
                  out_steer_command != CMD_NONE, "calibrated word has no command")
  `HCF_ASSERT_NOW(a_filt_range, 1'b1,
                  filt_r <= 17'sd36000 && filt_r >= -17'sd36000,
                  "filtered heading out of range")

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the heading controller core
module tb_top;
  import hcf_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 12;
  // index with no register behind it; writes to it must change nothing
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam logic [2:0] REG_ORDER [6] = '{REG_PROP_GAIN, REG_DERIV_GAIN, REG_FILTER_WEIGHT,
                                           REG_WARMUP_SAMPLES, REG_STRAIGHT_DRIVE, REG_UNUSED};

  typedef struct packed {
    logic [1:0]         cmd;
    logic [15:0]        drive;
    logic signed [16:0] heading;
    logic               cal;
  } steer_word_t;

  class steer_tracker;
    logic [15:0]        prop_gain;
    logic [15:0]        deriv_gain;
    logic [12:0]        filt_weight;
    logic [11:0]        warmup_target;
    logic [15:0]        straight_drive;
    logic [11:0]        warm_count;
    bit                 cal_done;
    logic signed [15:0] yaw_zero;
    logic signed [16:0] filt_heading;
    logic signed [17:0] last_err;
    steer_word_t        pending_words[$];
    int unsigned        mismatches;

    function new();
      prop_gain      = 16'd1843;
      deriv_gain     = 16'd2458;
      filt_weight    = 13'd2867;
      warmup_target  = 12'd2000;
      straight_drive = 16'd0;
      warm_count     = '0;
      cal_done       = 1'b0;
      yaw_zero       = '0;
      filt_heading   = '0;
      last_err       = '0;
      mismatches     = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        REG_PROP_GAIN:      prop_gain = val;
        REG_DERIV_GAIN:     deriv_gain = val;
        REG_FILTER_WEIGHT:  filt_weight = val[12:0];
        REG_WARMUP_SAMPLES: warmup_target = val[11:0];
        REG_STRAIGHT_DRIVE: straight_drive = val;
        default: ;
      endcase
    endfunction

    function longint clip_heading(longint v);
      if (v > HeadingLimit) return HeadingLimit;
      if (v < -HeadingLimit) return -HeadingLimit;
      return v;
    endfunction

    // runs one sample through offset removal, filter and PD law
    function void take_sample(logic sv, logic signed [15:0] yaw, logic signed [15:0] tgt);
      longint hd, w, c, acc, err, sum, u;
      steer_word_t word;
      hd = 0;
      word = '0;
      if (sv) begin
        if (!cal_done) begin
          if (warm_count != 12'hFFF) warm_count++;
          hd = yaw;
        end else begin
          w = (filt_weight > Q12One) ? Q12One : longint'(filt_weight);
          c = clip_heading(longint'(yaw) - longint'(yaw_zero));
          acc = (Q12One - w) * c + w * longint'(filt_heading) + Q12One / 2;
          hd = clip_heading(acc >>> 12);
          filt_heading = hd[16:0];
        end
      end
      if (!cal_done && sv && yaw != 0 && warm_count >= warmup_target) begin
        yaw_zero = yaw;
        cal_done = 1'b1;
      end
      if (cal_done) begin
        err = longint'(tgt) - hd;
        sum = longint'(prop_gain) * err + longint'(deriv_gain) * (err - longint'(last_err));
        u = sum / Q12One;
        last_err = err[17:0];
        if (u == 0) begin
          word.cmd = CMD_STRAIGHT;
          word.drive = straight_drive;
        end else if (u > 0) begin
          word.cmd = CMD_LEFT;
          word.drive = (u > 65535) ? 16'hFFFF : u[15:0];
        end else begin
          word.cmd = CMD_RIGHT;
          word.drive = (-u > 65535) ? 16'hFFFF : 16'(-u);
        end
      end else begin
        word.cmd = CMD_NONE;
      end
      word.heading = hd[16:0];
      word.cal = cal_done;
      pending_words.push_back(word);
    endfunction

    function void compare_field(string fname, logic signed [63:0] want,
                                logic signed [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, fname, want, got);
        mismatches++;
      end
    endfunction

    function void match_word(logic [1:0] cmd, logic [15:0] drive,
                             logic signed [16:0] heading, logic cal);
      steer_word_t want;
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual cmd %0d drive %0d heading %0d",
                 $time, cmd, drive, heading);
        mismatches++;
      end else begin
        want = pending_words.pop_front();
        compare_field("steer_command", want.cmd, cmd);
        compare_field("drive_level", want.drive, drive);
        compare_field("heading_now", want.heading, heading);
        compare_field("calibrated", want.cal, cal);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic [2:0]          cfg_index = REG_PROP_GAIN;
  logic [15:0]         cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_sample_valid = 1'b0;
  logic signed [15:0]  in_yaw_raw = '0;
  logic signed [15:0]  in_target_heading = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          out_steer_command;
  logic [15:0]         out_drive_level;
  logic signed [16:0]  out_heading_now;
  logic                out_calibrated;

  steer_tracker tracker = new();
  int burst_left = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  int stall_mode = 0;

  heading_calibrate_filter_pd_steer_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample_valid   (in_sample_valid),
    .in_yaw_raw        (in_yaw_raw),
    .in_target_heading (in_target_heading),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_steer_command (out_steer_command),
    .out_drive_level   (out_drive_level),
    .out_heading_now   (out_heading_now),
    .out_calibrated    (out_calibrated)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side: check accepted words, stall in changing modes
  always @(posedge clk) begin
    if (out_valid && !out_stall)
      tracker.match_word(out_steer_command, out_drive_level, out_heading_now, out_calibrated);
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(5, 60);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= stall_left[3];
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // all five registers plus the unused index, back to back
  task automatic set_regs(input logic [15:0] prop, input logic [15:0] deriv,
                          input logic [15:0] weight, input logic [15:0] warm,
                          input logic [15:0] drv);
    logic [15:0] vals [6];
    vals = '{prop, deriv, weight, warm, drv, 16'($urandom)};
    cfg_wr_en <= 1'b1;
    for (int i = 0; i < 6; i++) begin
      cfg_index <= REG_ORDER[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      tracker.set_reg(REG_ORDER[i], vals[i]);
    end
    cfg_wr_en <= 1'b0;
  endtask

  task automatic push_sample(input logic sv, input logic signed [15:0] yaw,
                             input logic signed [15:0] tgt);
    int gap;
    in_valid <= 1'b1;
    in_sample_valid <= sv;
    in_yaw_raw <= yaw;
    in_target_heading <= tgt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.take_sample(sv, yaw, tgt);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drain all expected words, then let the pipeline go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_items(input int count);
    logic sv;
    logic signed [15:0] yaw;
    logic signed [15:0] tgt;
    for (int i = 0; i < count; i++) begin
      sv = ($urandom_range(0, 9) != 0);
      case ($urandom_range(0, 4))
        0, 1: yaw = 16'($urandom_range(0, 36000) - 18000);
        2: yaw = 16'($urandom);
        default: yaw = 16'(tracker.yaw_zero + tracker.filt_heading + $urandom_range(0, 400) - 200);
      endcase
      case ($urandom_range(0, 3))
        0, 1: tgt = 16'($urandom_range(0, 36000) - 18000);
        2: tgt = 16'($urandom);
        // close to the current heading, so small corrections and straight runs show up
        default: tgt = 16'(tracker.filt_heading + $urandom_range(0, 4) - 2);
      endcase
      push_sample(sv, yaw, tgt);
    end
  endtask

  initial begin
    logic signed [15:0] zero_yaw;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero yaw never calibrates, however far the count runs past the warm-up
    set_regs(16'd1843, 16'd2458, 16'd2867, 16'd50, 16'd0);
    push_sample(1'b0, 16'sh7FFF, 16'sh8000);
    push_sample(1'b1, 16'sd0, 16'sd0);
    push_sample(1'b1, 16'sh7FFF, 16'sh7FFF);
    push_sample(1'b1, 16'sh8000, 16'sh8000);
    push_sample(1'b1, 16'sd18000, -16'sd18000);
    push_sample(1'b1, -16'sd18000, 16'sd18000);
    for (int i = 0; i < 60; i++) begin
      if ($urandom_range(0, 9) == 0) push_sample(1'b0, 16'($urandom), 16'($urandom));
      push_sample(1'b1, 16'sd0, 16'($urandom));
    end
    zero_yaw = -16'($urandom_range(20000, 32768));
    push_sample(1'b1, zero_yaw, 16'($urandom));
    settle();

    set_regs(16'd1843, 16'd2458, 16'd2867, 16'd0, 16'd12345);
    push_sample(1'b0, 16'($urandom), 16'sd0);
    push_sample(1'b0, 16'($urandom), 16'sh7FFF);
    push_sample(1'b0, 16'($urandom), 16'sh8000);
    push_sample(1'b1, zero_yaw, 16'sd0);
    push_sample(1'b1, 16'sh7FFF, 16'sh7FFF);
    push_sample(1'b1, 16'sh7FFF, 16'sh8000);
    push_sample(1'b1, 16'sh8000, 16'sh8000);
    push_sample(1'b1, 16'sh8000, 16'sh7FFF);
    push_sample(1'b1, 16'sd0, 16'sd0);
    for (int i = 0; i < 4; i++)
      push_sample(1'b1, zero_yaw, 16'(tracker.filt_heading));
    random_items(40);
    settle();

    // no gain: always straight; weight of one freezes the filter
    set_regs(16'd0, 16'd0, 16'd4096, 16'd1, 16'hFFFF);
    random_items(40);
    settle();

    set_regs(16'hFFFF, 16'hFFFF, 16'd0, 16'd4095, 16'd0);
    random_items(40);
    settle();

    set_regs(16'd4096, 16'hFFFF, 16'd8191, 16'd2000, 16'd777);
    random_items(40);
    settle();

    for (int p = 0; p < 4; p++) begin
      set_regs(($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8191)),
               ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8191)),
               ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 4096)) : 16'($urandom),
               16'($urandom), 16'($urandom));
      random_items(40);
      settle();
    end

    if (tracker.mismatches == 0 && tracker.pending_words.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
